>>> hw/rtl/lhn_pkg.sv
// Shared package for the luma histogram normalizer.
// Holds default sizes, command and status codes, and controller/datapath structs.
// No dependencies.
`default_nettype none

package lhn_pkg;

	localparam int MAX_BINS_DEF    = 256;
	localparam int COUNT_WIDTH_DEF = 24;

	localparam int CMD_W    = 2;
	localparam int PIX_W    = 8;
	localparam int BCNT_W   = 9;
	localparam int RAW_W    = 24;
	localparam int NORM_W   = 17;
	localparam int STATUS_W = 2;
	localparam int STEP_W   = 5;

	// divider runs one quotient bit per cycle, Q1.16 result
	localparam int DIV_STEPS = NORM_W;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ACCUM = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_HIST  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_BIN  = 2'd2;

	localparam logic CFG_BIN_COUNT   = 1'b0;
	localparam logic CFG_SOURCE_MODE = 1'b1;

	localparam logic [BCNT_W-1:0] BIN_COUNT_RST = 9'd128;
	localparam logic [NORM_W-1:0] NORM_ONE      = 17'h10000;

	typedef struct packed {
		logic load;       // capture pixel and read index
		logic clear;      // drop all counts and the maximum
		logic rd_acc;     // RAM read at the pixel's bin
		logic rd_bin;     // RAM read at the requested bin
		logic acc_write;  // write back incremented count
		logic div_init;
		logic div_step;
		logic out_load;
	} lhn_cmd_t;

	typedef struct packed {
		logic levels_zero;
		logic rd_bad;
		logic div_last;
	} lhn_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/lhn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lhn_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> hw/rtl/lhn_ctrl.sv
// Controller state machine for the luma histogram normalizer.
// Depends on lhn_pkg; drives lhn_dp through lhn_cmd_t.
`default_nettype none

module lhn_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [lhn_pkg::CMD_W-1:0] cmd,
	input  wire lhn_pkg::lhn_stat_t       st,
	output lhn_pkg::lhn_cmd_t             dc,
	output logic                          busy,
	output logic                          done
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_ACC_RD  = 3'd1;
	localparam logic [2:0] S_ACC_WR  = 3'd2;
	localparam logic [2:0] S_RD_RD   = 3'd3;
	localparam logic [2:0] S_RD_DATA = 3'd4;
	localparam logic [2:0] S_DIV     = 3'd5;
	localparam logic [2:0] S_OUT     = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       ready;

	// the result cycle also takes the next item
	assign ready = (state_q == S_IDLE) || (state_q == S_OUT);
	assign busy  = !ready;
	assign done  = (state_q == S_OUT);

	always_comb begin
		state_nxt = state_q;
		dc        = '0;
		case (state_q)
			S_IDLE, S_OUT: begin
				state_nxt = S_IDLE;
				if (start) begin
					case (cmd)
						lhn_pkg::CMD_CLEAR: begin
							dc.clear = 1'b1;
						end
						lhn_pkg::CMD_ACCUM: begin
							if (!st.levels_zero) begin
								dc.load   = 1'b1;
								state_nxt = S_ACC_RD;
							end
						end
						lhn_pkg::CMD_READ: begin
							dc.load   = 1'b1;
							state_nxt = S_RD_RD;
						end
						default: begin
						end
					endcase
				end
			end
			S_ACC_RD: begin
				dc.rd_acc = 1'b1;
				state_nxt = S_ACC_WR;
			end
			S_ACC_WR: begin
				dc.acc_write = 1'b1;
				state_nxt    = S_IDLE;
			end
			S_RD_RD: begin
				dc.rd_bin = 1'b1;
				state_nxt = S_RD_DATA;
			end
			S_RD_DATA: begin
				if (st.rd_bad) begin
					dc.out_load = 1'b1;
					state_nxt   = S_OUT;
				end else begin
					dc.div_init = 1'b1;
					state_nxt   = S_DIV;
				end
			end
			S_DIV: begin
				dc.div_step = 1'b1;
				if (st.div_last) begin
					dc.out_load = 1'b1;
					state_nxt   = S_OUT;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/lhn_dp.sv
// Datapath: config registers, bin count RAM with valid bits, running maximum,
// bit-serial divider and result registers. Depends on lhn_pkg and lhn_ram.
`default_nettype none

module lhn_dp #(
	parameter int MAX_BINS    = lhn_pkg::MAX_BINS_DEF,
	parameter int COUNT_WIDTH = lhn_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire lhn_pkg::lhn_cmd_t              dc,
	output lhn_pkg::lhn_stat_t                  st,
	input  wire logic                           cfg_we,
	input  wire logic                           cfg_index,
	input  wire logic [lhn_pkg::BCNT_W-1:0]     cfg_data,
	input  wire logic [lhn_pkg::PIX_W-1:0]      luma,
	input  wire logic [lhn_pkg::PIX_W-1:0]      red,
	input  wire logic [lhn_pkg::PIX_W-1:0]      green,
	input  wire logic [lhn_pkg::PIX_W-1:0]      blue,
	input  wire logic [lhn_pkg::PIX_W-1:0]      read_bin,
	output logic      [lhn_pkg::PIX_W-1:0]      bin_index,
	output logic      [lhn_pkg::RAW_W-1:0]      raw_count,
	output logic      [lhn_pkg::NORM_W-1:0]     normalized,
	output logic      [lhn_pkg::STATUS_W-1:0]   status
);

	localparam int AW = $clog2(MAX_BINS);
	localparam int CW = COUNT_WIDTH;
	localparam int BW = lhn_pkg::BCNT_W;
	localparam int PW = lhn_pkg::PIX_W;
	localparam int NW = lhn_pkg::NORM_W;
	localparam logic [BW-1:0] MAX_LEVELS = BW'(MAX_BINS);
	localparam logic [lhn_pkg::STEP_W-1:0] LAST_STEP = lhn_pkg::STEP_W'(lhn_pkg::DIV_STEPS - 1);

	logic [BW-1:0]   bin_count_q;
	logic            source_mode_q;
	logic [BW-1:0]   levels;
	logic [PW-1:0]   pix_q;
	logic [PW-1:0]   rb_q;
	logic [12:0]     gray_sum;
	logic [PW-1:0]   pix_in;
	logic [PW+BW-1:0] prod;
	logic [AW-1:0]   raddr;
	logic [AW-1:0]   addr_q;
	logic [MAX_BINS-1:0] valid_q;
	logic            rvalid_q;
	logic [CW-1:0]   rdata;
	logic [CW-1:0]   count;
	logic [CW-1:0]   count_inc;
	logic [CW-1:0]   max_q;
	logic [CW-1:0]   hold_q;
	logic [CW:0]     rem_q;
	logic [CW:0]     diff;
	logic [CW:0]     rem_sel;
	logic            ge;
	logic [NW-1:0]   quo_q;
	logic [NW-1:0]   quo_nxt;
	logic [NW-1:0]   norm_val;
	logic [lhn_pkg::STEP_W-1:0] step_q;
	logic            ram_we;
	logic            bad;

	assign levels = (bin_count_q > MAX_LEVELS) ? MAX_LEVELS : bin_count_q;

	// gray = (11r + 16g + 5b) / 32
	assign gray_sum = 13'(red) * 13'd11 + 13'(green) * 13'd16 + 13'(blue) * 13'd5;
	assign pix_in   = source_mode_q ? gray_sum[12:5] : luma;

	assign prod  = (PW+BW)'(pix_q) * (PW+BW)'(levels);
	assign raddr = dc.rd_bin ? AW'(rb_q) : AW'(prod[PW+BW-1:PW]);

	assign bad = (levels == '0) || ({1'b0, rb_q} >= levels);

	assign st.levels_zero = (levels == '0);
	assign st.rd_bad      = bad;
	assign st.div_last    = (step_q == LAST_STEP);

	// entries never written since the last clear read as zero
	assign count     = rvalid_q ? rdata : '0;
	assign count_inc = (&count) ? count : count + 1'b1;
	assign ram_we    = dc.acc_write;

	lhn_ram #(
		.WIDTH(CW),
		.DEPTH(MAX_BINS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_q),
		.wdata(count_inc),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign ge      = rem_q >= {1'b0, max_q};
	assign diff    = rem_q - {1'b0, max_q};
	assign rem_sel = ge ? diff : rem_q;
	assign quo_nxt = {quo_q[NW-2:0], ge};

	always_comb begin
		if (max_q == '0) begin
			norm_val = '0;
		end else if (quo_nxt > lhn_pkg::NORM_ONE) begin
			norm_val = lhn_pkg::NORM_ONE;
		end else begin
			norm_val = quo_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_count_q   <= lhn_pkg::BIN_COUNT_RST;
			source_mode_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == lhn_pkg::CFG_BIN_COUNT) begin
				bin_count_q <= cfg_data;
			end else begin
				source_mode_q <= cfg_data[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			max_q   <= '0;
		end else if (dc.clear) begin
			valid_q <= '0;
			max_q   <= '0;
		end else if (dc.acc_write) begin
			valid_q[addr_q] <= 1'b1;
			if (count_inc > max_q) begin
				max_q <= count_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dc.load) begin
			pix_q <= pix_in;
			rb_q  <= read_bin;
		end
		if (dc.rd_acc || dc.rd_bin) begin
			addr_q   <= raddr;
			rvalid_q <= valid_q[raddr];
		end
		if (dc.div_init) begin
			hold_q <= count;
			rem_q  <= {1'b0, count};
			quo_q  <= '0;
			step_q <= '0;
		end else if (dc.div_step) begin
			rem_q  <= {rem_sel[CW-1:0], 1'b0};
			quo_q  <= quo_nxt;
			step_q <= step_q + 1'b1;
		end
		if (dc.out_load) begin
			bin_index <= rb_q;
			if (levels == '0) begin
				status     <= lhn_pkg::ST_NO_HIST;
				raw_count  <= '0;
				normalized <= '0;
			end else if (bad) begin
				status     <= lhn_pkg::ST_BAD_BIN;
				raw_count  <= '0;
				normalized <= '0;
			end else begin
				status     <= lhn_pkg::ST_OK;
				raw_count  <= lhn_pkg::RAW_W'(hold_q);
				normalized <= norm_val;
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/luma_histogram_normalizer.sv
// Luma histogram normalizer. One item is taken when start is high and busy is
// low. A clear takes effect at its accept edge; an unknown command, or a pixel
// while no bins are in use, is dropped at once. A pixel holds busy after its
// accept through the bin RAM read, then write back with the maximum update,
// and no new item is taken until it is done. A read holds busy after its
// accept through RAM read, data capture, then the one-bit-per-cycle divider
// that forms count / maximum in Q1.16; a read with a bad status skips the
// divider. The result shows for one cycle with done high; the next item can
// be taken in that same cycle. Results cannot be held off. Configuration
// writes are always ready and should only be made while idle. Depends on
// lhn_pkg, lhn_ctrl, lhn_dp, lhn_ram.
`default_nettype none

module luma_histogram_normalizer #(
	parameter int MAX_BINS    = lhn_pkg::MAX_BINS_DEF,
	parameter int COUNT_WIDTH = lhn_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [lhn_pkg::CMD_W-1:0]        cmd,
	input  wire logic [lhn_pkg::PIX_W-1:0]        luma,
	input  wire logic [lhn_pkg::PIX_W-1:0]        red,
	input  wire logic [lhn_pkg::PIX_W-1:0]        green,
	input  wire logic [lhn_pkg::PIX_W-1:0]        blue,
	input  wire logic [lhn_pkg::PIX_W-1:0]        read_bin,
	output logic                                  done,
	output logic      [lhn_pkg::PIX_W-1:0]        bin_index,
	output logic      [lhn_pkg::RAW_W-1:0]        raw_count,
	output logic      [lhn_pkg::NORM_W-1:0]       normalized,
	output logic      [lhn_pkg::STATUS_W-1:0]     status,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic                             cfg_index,
	input  wire logic [lhn_pkg::BCNT_W-1:0]       cfg_data
);

	lhn_pkg::lhn_cmd_t  dc;
	lhn_pkg::lhn_stat_t st;

	assign cfg_ready = 1'b1;

	lhn_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.st    (st),
		.dc    (dc),
		.busy  (busy),
		.done  (done)
	);

	lhn_dp #(
		.MAX_BINS   (MAX_BINS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.dc        (dc),
		.st        (st),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.luma      (luma),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.read_bin  (read_bin),
		.bin_index (bin_index),
		.raw_count (raw_count),
		.normalized(normalized),
		.status    (status)
	);

endmodule

`default_nettype wire

>>> hw/rtl/lhn_checker.sv
// Port-level assertions for the luma histogram normalizer, bound to the top.
// Depends on lhn_pkg and luma_histogram_normalizer.
`default_nettype none

module lhn_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             start,
	input wire logic                             busy,
	input wire logic [lhn_pkg::CMD_W-1:0]        cmd,
	input wire logic                             done,
	input wire logic [lhn_pkg::RAW_W-1:0]        raw_count,
	input wire logic [lhn_pkg::NORM_W-1:0]       normalized,
	input wire logic [lhn_pkg::STATUS_W-1:0]     status
);

	// result cycle is also an accept slot
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held for more than one cycle");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != lhn_pkg::ST_OK) |-> (raw_count == '0 && normalized == '0))
		else $error("error result carries nonzero data");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (normalized <= lhn_pkg::NORM_ONE)) else $error("normalized above 1.0");

	a_clear_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == lhn_pkg::CMD_CLEAR) |=> !busy)
		else $error("clear left the block busy");

endmodule

bind luma_histogram_normalizer lhn_checker u_lhn_checker (.*);

`default_nettype wire
